### hw/rtl/framed_result_byte_parser_core_defines.svh
// Assertion macros for the frame parser.
`ifndef FRAMED_RESULT_BYTE_PARSER_CORE_DEFINES_SVH
`define FRAMED_RESULT_BYTE_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define FBP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("frame parser check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define FBP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("frame parser check failed");

`endif

### hw/rtl/fbp_pkg.sv
// Shared constants and types of the frame parser.
package fbp_pkg;

   localparam int unsigned BUFFER_BYTES = 32;
   localparam int unsigned POS_W        = 8;
   localparam int unsigned BYTE_W       = 8;

   localparam logic [POS_W:0]    POS_LIMIT     = (POS_W + 1)'(BUFFER_BYTES);
   localparam logic [BYTE_W-1:0] LENGTH_MIN    = 8'd2;
   localparam logic [BYTE_W-1:0] LENGTH_MAX    = 8'(BUFFER_BYTES - 2);

   localparam logic [BYTE_W-1:0] START_MARK    = 8'hAA;
   localparam logic [BYTE_W-1:0] END_MARK      = 8'h0A;
   localparam logic [BYTE_W-1:0] RESULT_CMD    = 8'h0D;

   localparam logic [POS_W-1:0]  POS_HUNT      = 8'd0;
   localparam logic [POS_W-1:0]  POS_LENGTH    = 8'd1;
   localparam logic [POS_W-1:0]  POS_CMD       = 8'd2;
   localparam logic [POS_W-1:0]  POS_RECORD    = 8'd5;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] rx_byte;
   } item_type;

endpackage

### hw/rtl/fbp_req_if.sv
// Request channel carrying one received byte per transfer.
interface fbp_req_if;
   logic                       valid;
   logic                       ready;
   logic [fbp_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

### hw/rtl/fbp_rsp_if.sv
// Response channel carrying one record number per transfer.
interface fbp_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [fbp_pkg::BYTE_W-1:0] record_number;

   modport source (output valid, output record_number, input ready);
   modport sink (input valid, input record_number, output ready);
endinterface

### hw/rtl/fbp_in_stage.sv
// Input register of the frame parser.
module fbp_in_stage (
   input  logic              clock,
   input  logic              reset,
   fbp_req_if.sink           req_chan,
   input  logic              advance,
   output fbp_pkg::item_type item
);

   logic                       valid_ff;
   logic                       valid_in;
   logic [fbp_pkg::BYTE_W-1:0] byte_ff;
   logic [fbp_pkg::BYTE_W-1:0] byte_in;
   logic                       take;

   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (take) begin
         valid_in = 1'b1;
         byte_in  = req_chan.rx_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign item.valid   = valid_ff;
   assign item.rx_byte = byte_ff;

endmodule

### hw/rtl/fbp_parse.sv
// Frame state update and result register of the frame parser.
`include "framed_result_byte_parser_core_defines.svh"

module fbp_parse (
   input  logic              clock,
   input  logic              reset,
   input  fbp_pkg::item_type item,
   output logic              advance,
   fbp_rsp_if.source         rsp_chan
);

   logic [fbp_pkg::POS_W-1:0]  pos_ff;
   logic [fbp_pkg::POS_W-1:0]  pos_in;
   logic [fbp_pkg::BYTE_W-1:0] len_ff;
   logic [fbp_pkg::BYTE_W-1:0] len_in;
   logic [fbp_pkg::BYTE_W-1:0] cmd_ff;
   logic [fbp_pkg::BYTE_W-1:0] cmd_in;
   logic [fbp_pkg::BYTE_W-1:0] rec_ff;
   logic [fbp_pkg::BYTE_W-1:0] rec_in;
   logic                       out_valid_ff;
   logic                       out_valid_in;
   logic [fbp_pkg::BYTE_W-1:0] out_rec_ff;
   logic [fbp_pkg::BYTE_W-1:0] out_rec_in;
   logic [fbp_pkg::POS_W:0]    pos_next;
   logic [fbp_pkg::POS_W:0]    total;
   logic                       hit;

   assign advance  = item.valid && (!out_valid_ff || rsp_chan.ready);
   assign pos_next = {1'b0, pos_ff} + (fbp_pkg::POS_W + 1)'(1);
   assign total    = {1'b0, len_ff} + (fbp_pkg::POS_W + 1)'(2);

   always_comb begin
      pos_in = pos_ff;
      len_in = len_ff;
      cmd_in = cmd_ff;
      rec_in = rec_ff;
      hit    = 1'b0;
      if (advance) begin
         if (pos_ff == fbp_pkg::POS_HUNT) begin
            if (item.rx_byte == fbp_pkg::START_MARK) begin
               pos_in = fbp_pkg::POS_LENGTH;
            end
         end else if (pos_ff == fbp_pkg::POS_LENGTH) begin
            if (item.rx_byte < fbp_pkg::LENGTH_MIN || item.rx_byte > fbp_pkg::LENGTH_MAX) begin
               pos_in = fbp_pkg::POS_HUNT;
            end else begin
               len_in = item.rx_byte;
               pos_in = fbp_pkg::POS_CMD;
            end
         end else begin
            if (pos_ff == fbp_pkg::POS_CMD) begin
               cmd_in = item.rx_byte;
            end
            if (pos_ff == fbp_pkg::POS_RECORD) begin
               rec_in = item.rx_byte;
            end
            if (pos_next >= total) begin
               pos_in = fbp_pkg::POS_HUNT;
               hit    = (item.rx_byte == fbp_pkg::END_MARK)
                        && (cmd_in == fbp_pkg::RESULT_CMD)
                        && (len_ff >= fbp_pkg::POS_RECORD);
            end else if (pos_next >= fbp_pkg::POS_LIMIT) begin
               pos_in = fbp_pkg::POS_HUNT;
            end else begin
               pos_in = pos_next[fbp_pkg::POS_W-1:0];
            end
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_rec_in   = out_rec_ff;
      if (hit) begin
         out_valid_in = 1'b1;
         out_rec_in   = rec_in;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= fbp_pkg::POS_HUNT;
         len_ff       <= '0;
         cmd_ff       <= '0;
         rec_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         len_ff       <= len_in;
         cmd_ff       <= cmd_in;
         rec_ff       <= rec_in;
         out_valid_ff <= out_valid_in;
      end
      out_rec_ff <= out_rec_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.record_number = out_rec_ff;

   `FBP_ASSERT_NOW(a_pos_in_buffer, 1'b1, {1'b0, pos_ff} < fbp_pkg::POS_LIMIT)
   `FBP_ASSERT_NOW(a_len_legal, pos_ff >= fbp_pkg::POS_CMD, len_ff >= fbp_pkg::LENGTH_MIN && len_ff <= fbp_pkg::LENGTH_MAX)
   `FBP_ASSERT_NOW(a_hit_at_tail, hit, pos_ff > fbp_pkg::POS_RECORD && advance)
   `FBP_ASSERT_NEXT(a_hit_returns_hunt, hit, pos_ff == fbp_pkg::POS_HUNT && out_valid_ff)
   `FBP_ASSERT_NEXT(a_hold_unparsed, item.valid && !advance, pos_ff == $past(pos_ff))

endmodule

### hw/rtl/framed_result_byte_parser_core.sv
// Frame parser top level: takes received bytes and returns record numbers of result frames.
// The block takes one byte per transfer and can accept a byte in every clock cycle; a byte
// passes an input register and the state update, and the record number of a valid frame is
// then registered in a result register that drives the response channel. A stalled
// response holds the state update, and the input register then stalls the request channel.
// Frames start with 0xAA and a length byte of 2 to BUFFER_BYTES-2; a frame that ends in 0x0A,
// carries command 0x0D and has a length of at least five returns the byte at offset five.
module framed_result_byte_parser_core (
   input logic       clock,
   input logic       reset,
   fbp_req_if.sink   req_chan,
   fbp_rsp_if.source rsp_chan
);

   fbp_pkg::item_type item;
   logic              advance;

   fbp_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .advance  (advance),
      .item     (item)
   );

   fbp_parse u_parse (
      .clock    (clock),
      .reset    (reset),
      .item     (item),
      .advance  (advance),
      .rsp_chan (rsp_chan)
   );

endmodule

### bench/testbench.sv
// Testbench for the frame parser: directed and random byte streams checked by a frame predictor.
`timescale 1ns / 1ps

module testbench;

   typedef logic [fbp_pkg::BYTE_W-1:0] byte_type;

   localparam int unsigned LONG_HOLD    = 200;
   localparam int unsigned STUCK_LIMIT  = 1000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned RANDOM_BYTES = 1150;
   localparam int unsigned STEADY_BYTES = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fbp_req_if req_chan ();
   fbp_rsp_if rsp_chan ();

   framed_result_byte_parser_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   byte_type    pending_records[$];
   byte_type    want;
   int unsigned failures      = 0;
   int unsigned bytes_sent    = 0;
   int unsigned stall_left    = 0;
   int unsigned stuck_cycles  = 0;
   int unsigned hold_requests = 0;
   int unsigned holds_taken   = 0;
   bit          idle_on       = 1'b0;

   logic [fbp_pkg::POS_W-1:0] parse_pos    = fbp_pkg::POS_HUNT;
   byte_type                  frame_len    = '0;
   byte_type                  frame_cmd    = '0;
   byte_type                  frame_record = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit parse_byte(input byte_type rx, output byte_type record);
      int unsigned next_pos;
      parse_byte = 1'b0;
      record = '0;
      if (parse_pos == fbp_pkg::POS_HUNT) begin
         if (rx == fbp_pkg::START_MARK) begin
            parse_pos = fbp_pkg::POS_LENGTH;
         end
      end else if (parse_pos == fbp_pkg::POS_LENGTH) begin
         if (rx < fbp_pkg::LENGTH_MIN || rx > fbp_pkg::LENGTH_MAX) begin
            parse_pos = fbp_pkg::POS_HUNT;
         end else begin
            frame_len = rx;
            parse_pos = fbp_pkg::POS_CMD;
         end
      end else begin
         if (parse_pos == fbp_pkg::POS_CMD) begin
            frame_cmd = rx;
         end
         if (parse_pos == fbp_pkg::POS_RECORD) begin
            frame_record = rx;
         end
         next_pos = 32'(parse_pos) + 32'd1;
         if (next_pos >= 32'(frame_len) + 32'd2) begin
            parse_byte = (rx == fbp_pkg::END_MARK) && (frame_cmd == fbp_pkg::RESULT_CMD) &&
                         (frame_len >= fbp_pkg::POS_RECORD);
            record = frame_record;
            parse_pos = fbp_pkg::POS_HUNT;
         end else if (next_pos >= fbp_pkg::BUFFER_BYTES) begin
            parse_pos = fbp_pkg::POS_HUNT;
         end else begin
            parse_pos = fbp_pkg::POS_W'(next_pos);
         end
      end
   endfunction

   task automatic send_byte(input byte_type rx);
      int unsigned gap;
      byte_type    record;
      gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 13) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.rx_byte = rx;
      do @(posedge clock); while (!req_chan.ready);
      bytes_sent++;
      if (parse_byte(rx, record)) begin
         pending_records.push_back(record);
      end
   endtask

   task automatic send_frame(input byte_type len, input byte_type cmd, input byte_type record,
                             input byte_type tail);
      int unsigned offset;
      send_byte(fbp_pkg::START_MARK);
      send_byte(len);
      if (len >= fbp_pkg::LENGTH_MIN && len <= fbp_pkg::LENGTH_MAX) begin
         for (offset = 32'(fbp_pkg::POS_CMD); offset <= 32'(len) + 32'd1; offset++) begin
            if (offset == 32'(len) + 32'd1) begin
               send_byte(tail);
            end else if (offset == 32'(fbp_pkg::POS_CMD)) begin
               send_byte(cmd);
            end else if (offset == 32'(fbp_pkg::POS_RECORD)) begin
               send_byte(record);
            end else begin
               send_byte(byte_type'($urandom));
            end
         end
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending_records.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_stream(input int unsigned n_bytes);
      int unsigned target;
      int unsigned pick;
      byte_type    odd;
      target = bytes_sent + n_bytes;
      while (bytes_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            send_frame(byte_type'($urandom_range(fbp_pkg::POS_RECORD, fbp_pkg::LENGTH_MAX)),
                       fbp_pkg::RESULT_CMD, byte_type'($urandom), fbp_pkg::END_MARK);
         end else if (pick < 72) begin
            odd = byte_type'($urandom);
            if (odd == fbp_pkg::RESULT_CMD) begin
               odd = odd ^ 8'h01;
            end
            send_frame(byte_type'($urandom_range(fbp_pkg::POS_RECORD, fbp_pkg::LENGTH_MAX)),
                       odd, byte_type'($urandom), fbp_pkg::END_MARK);
         end else if (pick < 79) begin
            odd = byte_type'($urandom);
            if (odd == fbp_pkg::END_MARK) begin
               odd = odd ^ 8'h01;
            end
            send_frame(byte_type'($urandom_range(fbp_pkg::POS_RECORD, fbp_pkg::LENGTH_MAX)),
                       fbp_pkg::RESULT_CMD, byte_type'($urandom), odd);
         end else if (pick < 84) begin
            send_frame(byte_type'($urandom_range(fbp_pkg::LENGTH_MIN,
                                                 fbp_pkg::POS_RECORD - 1)),
                       fbp_pkg::RESULT_CMD, byte_type'($urandom), fbp_pkg::END_MARK);
         end else if (pick < 92) begin
            odd = ($urandom_range(0, 3) == 0)
                  ? byte_type'($urandom_range(0, fbp_pkg::LENGTH_MIN - 1))
                  : byte_type'($urandom_range(fbp_pkg::LENGTH_MAX + 1, 255));
            send_frame(odd, fbp_pkg::RESULT_CMD, byte_type'($urandom), fbp_pkg::END_MARK);
         end else begin
            send_byte(byte_type'($urandom));
         end
      end
   endtask

   task automatic test_directed_frames();
      byte_type seq[7];
      idle_on = 1'b0;
      send_byte(8'h00);
      send_byte(8'hFF);
      seq = '{fbp_pkg::START_MARK, 8'd5, fbp_pkg::RESULT_CMD, fbp_pkg::START_MARK, 8'h55,
              8'hFF, fbp_pkg::END_MARK};
      foreach (seq[i]) begin
         send_byte(seq[i]);
      end
      send_frame(8'd5, fbp_pkg::RESULT_CMD, 8'h00, fbp_pkg::END_MARK);
      send_frame(fbp_pkg::START_MARK, fbp_pkg::RESULT_CMD, 8'h00, fbp_pkg::END_MARK);
      send_frame(fbp_pkg::LENGTH_MIN - 8'd1, fbp_pkg::RESULT_CMD, 8'h00, fbp_pkg::END_MARK);
      send_frame(fbp_pkg::LENGTH_MAX + 8'd1, fbp_pkg::RESULT_CMD, 8'h00, fbp_pkg::END_MARK);
      send_frame(fbp_pkg::POS_RECORD - 8'd1, fbp_pkg::RESULT_CMD, 8'h00, fbp_pkg::END_MARK);
      send_frame(fbp_pkg::LENGTH_MIN, fbp_pkg::RESULT_CMD, 8'h00, fbp_pkg::END_MARK);
      wait_drained();
   endtask

   task automatic test_random_stream();
      idle_on = 1'b1;
      run_stream(RANDOM_BYTES);
      wait_drained();
   endtask

   task automatic test_output_stall();
      idle_on = 1'b0;
      hold_requests++;
      repeat (8) begin
         send_frame(8'd5, fbp_pkg::RESULT_CMD, byte_type'($urandom), fbp_pkg::END_MARK);
      end
      wait_drained();
   endtask

   task automatic test_drain_pause();
      idle_on = 1'b1;
      repeat (4) begin
         send_frame(byte_type'($urandom_range(fbp_pkg::POS_RECORD, fbp_pkg::LENGTH_MAX)),
                    fbp_pkg::RESULT_CMD, byte_type'($urandom), fbp_pkg::END_MARK);
      end
      wait_drained();
      repeat (4) begin
         send_frame(byte_type'($urandom_range(fbp_pkg::POS_RECORD, fbp_pkg::LENGTH_MAX)),
                    fbp_pkg::RESULT_CMD, byte_type'($urandom), fbp_pkg::END_MARK);
      end
      wait_drained();
   endtask

   task automatic test_steady_stream();
      idle_on = 1'b0;
      run_stream(STEADY_BYTES);
      wait_drained();
   endtask

   // receiver: random stall bursts, plus one long hold on request
   initial begin
      rsp_chan.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (holds_taken != hold_requests) begin
            holds_taken = hold_requests;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            rsp_chan.ready = 1'b0;
            stall_left--;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_chan.ready = 1'b0;
            stall_left = $urandom_range(0, 12);
         end else begin
            rsp_chan.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_records.size() == 0) begin
               failures++;
               $display("%0t: record_number expected none, actual %02h", $time,
                        rsp_chan.record_number);
            end else begin
               want = pending_records.pop_front();
               if (rsp_chan.record_number !== want) begin
                  failures++;
                  $display("%0t: record_number expected %02h, actual %02h", $time, want,
                           rsp_chan.record_number);
               end
            end
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            stuck_cycles = 0;
         end else begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
               $display("Some tests failed");
               $finish;
            end
         end
      end
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.rx_byte = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_frames();
      test_random_stream();
      test_output_stall();
      test_drain_pause();
      test_steady_stream();
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/fbp_pkg.sv
hw/rtl/fbp_req_if.sv
hw/rtl/fbp_rsp_if.sv
hw/rtl/fbp_in_stage.sv
hw/rtl/fbp_parse.sv
hw/rtl/framed_result_byte_parser_core.sv
bench/testbench.sv
